@@ rtl/prc_pkg.sv @@
// Package for the Pareto rank and crowding unit.
// Holds the fixed field widths, the boundary constant, the divider request type and key compares.
// No dependencies.
`default_nettype none
package prc_pkg;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 6;
    localparam int LVL_W   = 7;
    localparam int DIST_W  = 23;
    localparam int QUOT_W  = 17;
    localparam logic [DIST_W-1:0] BOUNDARY_Q16 = 23'd6553600;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] gap;
        logic [VAL_W-1:0] span;
    } t_div_req;

    // time order: ascending time, then load index
    function automatic logic f_time_before(input logic [VAL_W-1:0] ta, input logic [IDX_W-1:0] ia,
                                           input logic [VAL_W-1:0] tb, input logic [IDX_W-1:0] ib);
        f_time_before = (ta < tb) || ((ta == tb) && (ia < ib));
    endfunction

    // memory order: descending memory, then ascending time, then load index
    function automatic logic f_mem_before(input logic [VAL_W-1:0] ma, input logic [VAL_W-1:0] ta,
                                          input logic [IDX_W-1:0] ia,
                                          input logic [VAL_W-1:0] mb, input logic [VAL_W-1:0] tb,
                                          input logic [IDX_W-1:0] ib);
        f_mem_before = (ma > mb) || ((ma == mb) && ((ta < tb) || ((ta == tb) && (ia < ib))));
    endfunction
endpackage
`default_nettype wire

@@ rtl/prc_pt_if.sv @@
// Input channel interface: one point per transaction.
// Depends on prc_pkg.
`default_nettype none
interface prc_pt_if;
    logic                      valid;
    logic                      ready;
    logic [prc_pkg::VAL_W-1:0] time_value;
    logic [prc_pkg::VAL_W-1:0] memory_value;
    logic                      last_point;
    modport source(output valid, time_value, memory_value, last_point, input ready);
    modport sink(input valid, time_value, memory_value, last_point, output ready);
endinterface
`default_nettype wire

@@ rtl/prc_res_if.sv @@
// Output channel interface: one result per transaction.
// Depends on prc_pkg.
`default_nettype none
interface prc_res_if;
    logic                       valid;
    logic                       ready;
    logic [prc_pkg::IDX_W-1:0]  point_index;
    logic [prc_pkg::LVL_W-1:0]  pareto_level;
    logic [prc_pkg::DIST_W-1:0] crowd_distance;
    logic                       last_result;
    modport source(output valid, point_index, pareto_level, crowd_distance, last_result,
                   input ready);
    modport sink(input valid, point_index, pareto_level, crowd_distance, last_result,
                 output ready);
endinterface
`default_nettype wire

@@ rtl/pareto_rank_and_crowding_unit.sv @@
// Pareto rank and crowding unit: points load one a cycle; the last point starts ranking.
// Ranking peels fronts level by level, at most n levels.
// Crowding per point: a scan of all points, two divider issue states (S_C_D1, S_C_D2), up to two
// divider waits, then one output transaction.
// Input is not ready from the last point until the final result is taken.
// Synchronous active-low reset clears point count and sequencer; stores stay undefined.
// Depends on prc_pkg, prc_pt_if, prc_res_if, prc_store, prc_div.
`default_nettype none
module pareto_rank_and_crowding_unit #(
    parameter int POINTS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    prc_pt_if.sink     i_pt,
    prc_res_if.source  o_res
);
    localparam int IW = $clog2(POINTS);
    localparam int CW = $clog2(POINTS + 1);
    localparam int VW = prc_pkg::VAL_W;

    typedef enum logic [3:0] {
        S_LOAD, S_P_RDI, S_P_GI, S_P_RDJ, S_P_GJ, S_P_WR, S_P_CHK,
        S_C_RDI, S_C_GI, S_C_RDJ, S_C_GJ, S_C_D1, S_C_W1, S_C_D2, S_C_W2, S_C_OUT
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_cnt, r_n, r_left;
    logic [IW-1:0] r_i, r_j;
    logic [prc_pkg::LVL_W-1:0] r_lvl, r_li;
    logic [VW-1:0] r_ti, r_mi;
    logic r_blocked;
    logic [VW-1:0] r_tmin, r_tmax, r_mmin, r_mmax;
    logic r_hp, r_hs, r_mhp, r_mhs;
    logic [VW-1:0] r_tp, r_ts, r_mp, r_mpt, r_ms, r_mst;
    logic [IW-1:0] r_pj, r_sj, r_mpj, r_msj;
    logic [prc_pkg::QUOT_W-1:0] r_q1;
    logic r_ov;

    logic [IW-1:0] w_raddr, w_waddr;
    logic w_we_pt, w_we_lvl;
    logic [prc_pkg::LVL_W-1:0] w_wlvl;
    logic [VW-1:0] w_tj, w_mj;
    logic [prc_pkg::LVL_W-1:0] w_lj;
    logic w_accept, w_store, w_last_i, w_last_j;
    logic [prc_pkg::IDX_W-1:0] w_i6, w_j6;
    logic w_beats, w_tbef, w_mbef;
    logic w_t_int, w_m_int;
    logic [prc_pkg::DIST_W-1:0] w_tpart, w_dist;
    prc_pkg::t_div_req w_req;
    logic w_ddone;
    logic [prc_pkg::QUOT_W-1:0] w_quot;

    assign i_pt.ready = (r_state == S_LOAD);
    assign w_accept   = i_pt.valid && i_pt.ready;
    assign w_store    = w_accept && (r_cnt < CW'(POINTS));
    assign w_last_i   = (CW'(r_i) == r_n - CW'(1));
    assign w_last_j   = (CW'(r_j) == r_n - CW'(1));
    assign w_i6       = prc_pkg::IDX_W'(r_i);
    assign w_j6       = prc_pkg::IDX_W'(r_j);

    always_comb begin
        case (r_state)
            S_P_RDJ, S_C_RDJ: w_raddr = r_j;
            default:          w_raddr = r_i;
        endcase
        w_we_pt  = w_store;
        w_we_lvl = w_store || ((r_state == S_P_WR) && !r_blocked);
        w_waddr  = (r_state == S_LOAD) ? r_cnt[IW-1:0] : r_i;
        w_wlvl   = (r_state == S_LOAD) ? '0 : r_lvl;
    end

    prc_store #(.POINTS(POINTS), .IW(IW)) u_store (
        .i_clk   (i_clk),
        .i_we_pt (w_we_pt),
        .i_we_lvl(w_we_lvl),
        .i_waddr (w_waddr),
        .i_wtime (i_pt.time_value),
        .i_wmem  (i_pt.memory_value),
        .i_wlvl  (w_wlvl),
        .i_raddr (w_raddr),
        .o_time  (w_tj),
        .o_mem   (w_mj),
        .o_lvl   (w_lj)
    );

    assign w_t_int = r_hp && r_hs && (r_tmax != r_tmin);
    assign w_m_int = r_mhp && r_mhs && (r_mmax != r_mmin);

    always_comb begin
        w_req = '0;
        if (r_state == S_C_D1) begin
            w_req.start = w_t_int;
            w_req.gap   = r_ts - r_tp;
            w_req.span  = r_tmax - r_tmin;
        end else if (r_state == S_C_D2) begin
            w_req.start = w_m_int;
            w_req.gap   = r_mp - r_ms;
            w_req.span  = r_mmax - r_mmin;
        end
    end

    prc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_ddone),
        .o_quot (w_quot)
    );

    assign w_beats = !((w_tj == r_ti) && (w_mj == r_mi)) && (w_tj <= r_ti) && (w_mj <= r_mi);
    assign w_tbef  = prc_pkg::f_time_before(w_tj, w_j6, r_ti, w_i6);
    assign w_mbef  = prc_pkg::f_mem_before(w_mj, w_tj, w_j6, r_mi, r_ti, w_i6);

    assign w_tpart = w_t_int ? prc_pkg::DIST_W'(r_q1) : prc_pkg::BOUNDARY_Q16;

    always_comb begin
        if (r_state == S_C_W2) begin
            w_dist = w_tpart + prc_pkg::DIST_W'(w_quot);
        end else begin
            w_dist = prc_pkg::BOUNDARY_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_n     <= '0;
            r_left  <= '0;
            r_ov    <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_store) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (w_accept && i_pt.last_point) begin
                        r_n     <= r_cnt + CW'(w_store);
                        r_left  <= r_cnt + CW'(w_store);
                        r_i     <= '0;
                        r_lvl   <= prc_pkg::LVL_W'(1);
                        r_state <= S_P_RDI;
                    end
                end
                S_P_RDI: r_state <= S_P_GI;
                S_P_GI: begin
                    r_ti      <= w_tj;
                    r_mi      <= w_mj;
                    r_j       <= '0;
                    r_blocked <= 1'b0;
                    if (w_lj != '0) begin
                        r_state <= w_last_i ? S_P_CHK : S_P_RDI;
                        if (!w_last_i) begin
                            r_i <= r_i + IW'(1);
                        end
                    end else begin
                        r_state <= S_P_RDJ;
                    end
                end
                S_P_RDJ: r_state <= S_P_GJ;
                S_P_GJ: begin
                    if (((w_lj == '0) || (w_lj == r_lvl)) && w_beats) begin
                        r_blocked <= 1'b1;
                    end
                    r_j     <= r_j + IW'(1);
                    r_state <= w_last_j ? S_P_WR : S_P_RDJ;
                end
                S_P_WR: begin
                    if (!r_blocked) begin
                        r_left <= r_left - CW'(1);
                    end
                    r_state <= w_last_i ? S_P_CHK : S_P_RDI;
                    if (!w_last_i) begin
                        r_i <= r_i + IW'(1);
                    end
                end
                S_P_CHK: begin
                    r_i <= '0;
                    if (r_left == '0) begin
                        r_state <= S_C_RDI;
                    end else begin
                        r_lvl   <= r_lvl + prc_pkg::LVL_W'(1);
                        r_state <= S_P_RDI;
                    end
                end
                S_C_RDI: r_state <= S_C_GI;
                S_C_GI: begin
                    r_ti   <= w_tj;
                    r_mi   <= w_mj;
                    r_li   <= w_lj;
                    r_tmin <= w_tj;
                    r_tmax <= w_tj;
                    r_mmin <= w_mj;
                    r_mmax <= w_mj;
                    r_hp   <= 1'b0;
                    r_hs   <= 1'b0;
                    r_mhp  <= 1'b0;
                    r_mhs  <= 1'b0;
                    r_j    <= '0;
                    r_state <= S_C_RDJ;
                end
                S_C_RDJ: r_state <= S_C_GJ;
                S_C_GJ: begin
                    if ((w_lj == r_li) && (r_j != r_i)) begin
                        if (w_tj < r_tmin) r_tmin <= w_tj;
                        if (w_tj > r_tmax) r_tmax <= w_tj;
                        if (w_mj < r_mmin) r_mmin <= w_mj;
                        if (w_mj > r_mmax) r_mmax <= w_mj;
                        if (w_tbef) begin
                            if (!r_hp || prc_pkg::f_time_before(r_tp, prc_pkg::IDX_W'(r_pj),
                                                                w_tj, w_j6)) begin
                                r_hp <= 1'b1;
                                r_tp <= w_tj;
                                r_pj <= r_j;
                            end
                        end else begin
                            if (!r_hs || prc_pkg::f_time_before(w_tj, w_j6,
                                                                r_ts, prc_pkg::IDX_W'(r_sj))) begin
                                r_hs <= 1'b1;
                                r_ts <= w_tj;
                                r_sj <= r_j;
                            end
                        end
                        if (w_mbef) begin
                            if (!r_mhp || prc_pkg::f_mem_before(r_mp, r_mpt,
                                    prc_pkg::IDX_W'(r_mpj), w_mj, w_tj, w_j6)) begin
                                r_mhp <= 1'b1;
                                r_mp  <= w_mj;
                                r_mpt <= w_tj;
                                r_mpj <= r_j;
                            end
                        end else begin
                            if (!r_mhs || prc_pkg::f_mem_before(w_mj, w_tj, w_j6,
                                    r_ms, r_mst, prc_pkg::IDX_W'(r_msj))) begin
                                r_mhs <= 1'b1;
                                r_ms  <= w_mj;
                                r_mst <= w_tj;
                                r_msj <= r_j;
                            end
                        end
                    end
                    r_j     <= r_j + IW'(1);
                    r_state <= w_last_j ? S_C_D1 : S_C_RDJ;
                end
                S_C_D1: r_state <= w_t_int ? S_C_W1 : S_C_D2;
                S_C_W1: begin
                    if (w_ddone) begin
                        r_q1    <= w_quot;
                        r_state <= S_C_D2;
                    end
                end
                S_C_D2: begin
                    if (w_m_int) begin
                        r_state <= S_C_W2;
                    end else begin
                        r_ov                 <= 1'b1;
                        o_res.point_index    <= w_i6;
                        o_res.pareto_level   <= r_li;
                        o_res.crowd_distance <= w_dist;
                        o_res.last_result    <= w_last_i;
                        r_state              <= S_C_OUT;
                    end
                end
                S_C_W2: begin
                    if (w_ddone) begin
                        r_ov                 <= 1'b1;
                        o_res.point_index    <= w_i6;
                        o_res.pareto_level   <= r_li;
                        o_res.crowd_distance <= w_dist;
                        o_res.last_result    <= w_last_i;
                        r_state              <= S_C_OUT;
                    end
                end
                S_C_OUT: begin
                    if (o_res.ready) begin
                        r_ov <= 1'b0;
                        if (w_last_i) begin
                            r_cnt   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= S_C_RDI;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_res.valid = r_ov;

    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.ready |-> !o_res.valid)
        else $error("input ready while a result is pending");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.last_result) |=> (r_cnt == '0))
        else $error("point count not cleared after final result");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_left <= r_n))
        else $error("unranked count exceeds population");
endmodule
`default_nettype wire

@@ rtl/prc_store.sv @@
// Point memories: time, memory and level, one write and one registered read port.
// Depends on prc_pkg.
`default_nettype none
module prc_store #(
    parameter int POINTS = 32,
    parameter int IW = $clog2(POINTS)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we_pt,
    input  wire logic                      i_we_lvl,
    input  wire logic [IW-1:0]             i_waddr,
    input  wire logic [prc_pkg::VAL_W-1:0] i_wtime,
    input  wire logic [prc_pkg::VAL_W-1:0] i_wmem,
    input  wire logic [prc_pkg::LVL_W-1:0] i_wlvl,
    input  wire logic [IW-1:0]             i_raddr,
    output logic      [prc_pkg::VAL_W-1:0] o_time,
    output logic      [prc_pkg::VAL_W-1:0] o_mem,
    output logic      [prc_pkg::LVL_W-1:0] o_lvl
);
    logic [prc_pkg::VAL_W-1:0] r_time_mem [POINTS];
    logic [prc_pkg::VAL_W-1:0] r_mem_mem  [POINTS];
    logic [prc_pkg::LVL_W-1:0] r_lvl_mem  [POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we_pt) begin
            r_time_mem[i_waddr] <= i_wtime;
            r_mem_mem[i_waddr]  <= i_wmem;
        end
        if (i_we_lvl) begin
            r_lvl_mem[i_waddr] <= i_wlvl;
        end
        o_time <= r_time_mem[i_raddr];
        o_mem  <= r_mem_mem[i_raddr];
        o_lvl  <= r_lvl_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/prc_div.sv @@
// Shared restoring divider: floor((gap << 16) / span) for gap <= span, one bit a cycle.
// Depends on prc_pkg.
`default_nettype none
module prc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire prc_pkg::t_div_req          i_req,
    output logic                            o_done,
    output logic      [prc_pkg::QUOT_W-1:0] o_quot
);
    logic [prc_pkg::VAL_W-1:0] r_rem;
    logic [prc_pkg::VAL_W-1:0] r_span;
    logic [4:0]                r_cnt;
    logic                      r_busy;
    logic                      r_first;
    logic [prc_pkg::VAL_W:0]   w_trial;

    assign w_trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_rem   <= i_req.gap;
                r_span  <= i_req.span;
                r_cnt   <= 5'(prc_pkg::QUOT_W - 1);
                o_quot  <= '0;
            end else if (r_busy) begin
                r_first <= 1'b0;
                if (w_trial >= {1'b0, r_span}) begin
                    r_rem  <= prc_pkg::VAL_W'(w_trial - {1'b0, r_span});
                    o_quot <= {o_quot[prc_pkg::QUOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= prc_pkg::VAL_W'(w_trial);
                    o_quot <= {o_quot[prc_pkg::QUOT_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire
